### src/sbmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmm_pkg: shared types and constants of the stereo bass mono mixer
// Sample, coefficient and state widths, multiplier operand codes and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package sbmm_pkg;

  // Field widths
  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS   = 16;
  localparam int AMT_W       = 17;               // ramp amount, Q1.16
  localparam int AMOUNT_FRAC = 16;
  localparam int AMOUNT_ONE  = 65536;
  localparam int ST_W        = 32;               // lowpass state width
  localparam int GUARD_BITS  = ST_W - SAMPLE_BITS;

  // Configuration port
  localparam int CFG_W   = (COEF_BITS > AMT_W) ? COEF_BITS : AMT_W;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd3;

  localparam logic [COEF_BITS-1:0] ALPHA_RESET  = COEF_BITS'(1022);
  localparam logic [COEF_BITS-1:0] SMOOTH_RESET = COEF_BITS'(55);
  localparam logic [AMT_W-1:0]     TARGET_RESET = AMT_W'(AMOUNT_ONE);

  // Shared multiplier: signed A operand times signed B operand
  localparam int MUL_A_W = ST_W + 1;
  localparam int MUL_B_W = CFG_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int EXT_W   = ST_W + 2;             // residual plus blend

  // Rounding offsets (half of one output LSB)
  localparam int COEF_HALF  = 2 ** (COEF_BITS - 1);
  localparam int AMT_HALF   = 2 ** (AMOUNT_FRAC - 1);
  localparam int GUARD_HALF = (GUARD_BITS > 0) ? 2 ** (GUARD_BITS - 1) : 0;

  // Saturation bounds of the sample range
  localparam logic signed [EXT_W-1:0] SAT_MAX = EXT_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [EXT_W-1:0] SAT_MIN = EXT_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

  // Multiplier operand selection
  localparam int MUL_OP_W = 3;
  localparam logic [MUL_OP_W-1:0] MUL_LOW_L   = 3'd0;
  localparam logic [MUL_OP_W-1:0] MUL_LOW_R   = 3'd1;
  localparam logic [MUL_OP_W-1:0] MUL_AMT     = 3'd2;
  localparam logic [MUL_OP_W-1:0] MUL_BLEND_L = 3'd3;
  localparam logic [MUL_OP_W-1:0] MUL_BLEND_R = 3'd4;

  // Controller to datapath
  typedef struct packed {
    logic                load_x;     // latch the accepted item
    logic                mul_en;     // register a product
    logic [MUL_OP_W-1:0] mul_op;
    logic                wb_low_l;   // add rounded product to left state
    logic                wb_low_r;
    logic                wb_amt;
    logic                load_mono;
    logic                load_res_l; // finish left sample from product
    logic                load_out;   // load output registers
    logic                pass;       // output the raw item
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic enable;
  } stat_t;

endpackage

### src/stereo_bass_mono_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_bass_mono_mixer: mono-bass crossover for stereo frames
// Splits each channel with a one-pole lowpass, blends the low bands toward
// their mono average by a smoothed amount and adds the highs back.
// ----------------------------------------------------------------------------
// One frame is taken per item. With processing enabled, an accepted frame
// steps through the left lowpass, right lowpass, ramp, mono, left blend and
// right blend states, and its result is loaded into the output register once
// that register is free. The next frame is taken only after that load. A
// single shared 33x18 multiplier handles both lowpass updates, the amount
// ramp and both blends in turn. With processing disabled, a frame is copied
// to the output register from the pass state once that register is free.
// The output register holds one finished frame, so the next frame is taken
// while the previous result still waits on out_stall. Register writes must go
// in only while no frame is in flight; the block itself does not enforce this.
// Switching enable from 0 to 1 clears the filter states and the ramp.
module stereo_bass_mono_mixer (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_we,
  input  logic [sbmm_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [sbmm_pkg::CFG_W-1:0]              cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [sbmm_pkg::SAMPLE_BITS-1:0] in_left_in,
  input  logic signed [sbmm_pkg::SAMPLE_BITS-1:0] in_right_in,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [sbmm_pkg::SAMPLE_BITS-1:0] out_left_out,
  output logic signed [sbmm_pkg::SAMPLE_BITS-1:0] out_right_out
);

  sbmm_pkg::cmd_t  cmd;
  sbmm_pkg::stat_t stat;

  // Sequencer
  sbmm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Arithmetic and storage
  sbmm_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_left_in    (in_left_in),
    .in_right_in   (in_right_in),
    .out_left_out  (out_left_out),
    .out_right_out (out_right_out),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule

### src/sbmm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmm_ctrl: sequencer of the stereo bass mono mixer
// Walks one frame through the shared multiplier and owns the handshakes
// and the valid flag of the output register.
// ----------------------------------------------------------------------------
module sbmm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  sbmm_pkg::stat_t stat,
  output sbmm_pkg::cmd_t  cmd
);

  localparam int S_W = 3;
  localparam logic [S_W-1:0] S_IDLE    = 3'd0;
  localparam logic [S_W-1:0] S_PASS    = 3'd1;
  localparam logic [S_W-1:0] S_MUL_L   = 3'd2;
  localparam logic [S_W-1:0] S_MUL_R   = 3'd3;
  localparam logic [S_W-1:0] S_MUL_A   = 3'd4;
  localparam logic [S_W-1:0] S_MONO    = 3'd5;
  localparam logic [S_W-1:0] S_BLEND_L = 3'd6;
  localparam logic [S_W-1:0] S_BLEND_R = 3'd7;

  logic [S_W-1:0] state_r, state_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           in_acc;
  logic           out_free;
  logic           fin_r, fin_nxt;   // last step of a processed frame pending

  assign in_stall  = (state_r != S_IDLE) || fin_r;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    fin_nxt       = fin_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.mul_op    = sbmm_pkg::MUL_LOW_L;
    case (state_r)
      S_IDLE: begin
        if (fin_r) begin
          // right channel finishes straight from the product register
          if (out_free) begin
            cmd.load_out  = 1'b1;
            out_valid_nxt = 1'b1;
            fin_nxt       = 1'b0;
          end
        end else if (in_acc) begin
          cmd.load_x = 1'b1;
          state_nxt  = stat.enable ? S_MUL_L : S_PASS;
        end
      end
      S_PASS: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          cmd.pass      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_MUL_L: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = sbmm_pkg::MUL_LOW_L;
        state_nxt  = S_MUL_R;
      end
      S_MUL_R: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_op   = sbmm_pkg::MUL_LOW_R;
        cmd.wb_low_l = 1'b1;
        state_nxt    = S_MUL_A;
      end
      S_MUL_A: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_op   = sbmm_pkg::MUL_AMT;
        cmd.wb_low_r = 1'b1;
        state_nxt    = S_MONO;
      end
      S_MONO: begin
        cmd.wb_amt    = 1'b1;
        cmd.load_mono = 1'b1;
        state_nxt     = S_BLEND_L;
      end
      S_BLEND_L: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = sbmm_pkg::MUL_BLEND_L;
        state_nxt  = S_BLEND_R;
      end
      S_BLEND_R: begin
        cmd.mul_en     = 1'b1;
        cmd.mul_op     = sbmm_pkg::MUL_BLEND_R;
        cmd.load_res_l = 1'b1;
        fin_nxt        = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### src/sbmm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmm_dp: datapath of the stereo bass mono mixer
// Configuration registers, lowpass and ramp state, one shared multiplier
// with a product register, rounding, saturation and the output registers.
// ----------------------------------------------------------------------------
module sbmm_dp (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        cfg_we,
  input  logic [sbmm_pkg::CFG_IDX_W-1:0]              cfg_index,
  input  logic [sbmm_pkg::CFG_W-1:0]                  cfg_data,
  input  logic signed [sbmm_pkg::SAMPLE_BITS-1:0]     in_left_in,
  input  logic signed [sbmm_pkg::SAMPLE_BITS-1:0]     in_right_in,
  output logic signed [sbmm_pkg::SAMPLE_BITS-1:0]     out_left_out,
  output logic signed [sbmm_pkg::SAMPLE_BITS-1:0]     out_right_out,
  input  sbmm_pkg::cmd_t                              cmd,
  output sbmm_pkg::stat_t                             stat
);

  localparam int SB  = sbmm_pkg::SAMPLE_BITS;
  localparam int CB  = sbmm_pkg::COEF_BITS;
  localparam int AW  = sbmm_pkg::AMT_W;
  localparam int SW  = sbmm_pkg::ST_W;
  localparam int GB  = sbmm_pkg::GUARD_BITS;
  localparam int MAW = sbmm_pkg::MUL_A_W;
  localparam int MBW = sbmm_pkg::MUL_B_W;
  localparam int PW  = sbmm_pkg::PROD_W;
  localparam int EW  = sbmm_pkg::EXT_W;

  // Configuration registers
  logic          enable_r;
  logic [CB-1:0] alpha_r;
  logic [CB-1:0] smooth_r;
  logic [AW-1:0] target_r;
  logic [AW-1:0] target_wr;
  logic          en_rise;

  // Frame and state registers
  logic signed [SB-1:0] x_l_r, x_r_r;
  logic signed [SW-1:0] low_l_r, low_r_r, mono_r;
  logic [AW-1:0]        amt_r;
  logic signed [PW-1:0] prod_r;
  logic signed [SB-1:0] res_l_r;
  logic signed [SB-1:0] out_l_r, out_r_r;

  // Combinational
  logic signed [SW-1:0]  el_l, el_r;
  logic signed [MAW-1:0] mul_a;
  logic signed [MBW-1:0] mul_b;
  logic signed [PW-1:0]  prod_nxt;
  logic signed [PW-1:0]  rnd_coef;
  logic signed [PW-1:0]  rnd_blend;
  logic signed [SW:0]    low_sum;
  logic signed [EW-1:0]  fin_y;
  logic signed [EW-1:0]  fin_rnd;
  logic signed [SB-1:0]  fin_sat;
  logic                  fin_right;

  assign stat.enable = enable_r;

  // Target write clamps to fully mono
  assign target_wr = (cfg_data[AW-1:0] > AW'(sbmm_pkg::AMOUNT_ONE)) ?
                     AW'(sbmm_pkg::AMOUNT_ONE) : cfg_data[AW-1:0];
  assign en_rise   = cfg_we && (cfg_index == sbmm_pkg::REG_ENABLE) &&
                     cfg_data[0] && !enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      alpha_r  <= sbmm_pkg::ALPHA_RESET;
      smooth_r <= sbmm_pkg::SMOOTH_RESET;
      target_r <= sbmm_pkg::TARGET_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sbmm_pkg::REG_ENABLE: enable_r <= cfg_data[0];
        sbmm_pkg::REG_ALPHA:  alpha_r  <= cfg_data[CB-1:0];
        sbmm_pkg::REG_SMOOTH: smooth_r <= cfg_data[CB-1:0];
        sbmm_pkg::REG_TARGET: target_r <= target_wr;
        default: ;
      endcase
    end
  end

  // Samples scaled up to state precision
  assign el_l = SW'(x_l_r) <<< GB;
  assign el_r = SW'(x_r_r) <<< GB;

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_op)
      sbmm_pkg::MUL_LOW_L: begin
        mul_a = MAW'(el_l) - MAW'(low_l_r);
        mul_b = MBW'(alpha_r);
      end
      sbmm_pkg::MUL_LOW_R: begin
        mul_a = MAW'(el_r) - MAW'(low_r_r);
        mul_b = MBW'(alpha_r);
      end
      sbmm_pkg::MUL_AMT: begin
        mul_a = MAW'(target_r) - MAW'(amt_r);
        mul_b = MBW'(smooth_r);
      end
      sbmm_pkg::MUL_BLEND_L: begin
        mul_a = MAW'(mono_r) - MAW'(low_l_r);
        mul_b = MBW'(amt_r);
      end
      sbmm_pkg::MUL_BLEND_R: begin
        mul_a = MAW'(mono_r) - MAW'(low_r_r);
        mul_b = MBW'(amt_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  // Round-to-nearest of the registered product
  assign rnd_coef  = (prod_r + PW'(sbmm_pkg::COEF_HALF)) >>> CB;
  assign rnd_blend = (prod_r + PW'(sbmm_pkg::AMT_HALF)) >>> sbmm_pkg::AMOUNT_FRAC;

  // Mono low band, floor of the average
  assign low_sum = (SW + 1)'(low_l_r) + (SW + 1)'(low_r_r);

  // Output: x - low + blend reduces to x plus the rounded blend offset
  assign fin_right = !cmd.load_res_l;
  assign fin_y     = (fin_right ? EW'(el_r) : EW'(el_l)) + rnd_blend[EW-1:0];
  assign fin_rnd   = (fin_y + EW'(sbmm_pkg::GUARD_HALF)) >>> GB;

  always_comb begin
    if (fin_rnd > sbmm_pkg::SAT_MAX) begin
      fin_sat = sbmm_pkg::SAT_MAX[SB-1:0];
    end else if (fin_rnd < sbmm_pkg::SAT_MIN) begin
      fin_sat = sbmm_pkg::SAT_MIN[SB-1:0];
    end else begin
      fin_sat = fin_rnd[SB-1:0];
    end
  end

  // Filter and ramp state, cleared when processing is switched on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_l_r <= '0;
      low_r_r <= '0;
      amt_r   <= '0;
    end else if (en_rise) begin
      low_l_r <= '0;
      low_r_r <= '0;
      amt_r   <= '0;
    end else begin
      if (cmd.wb_low_l) begin
        low_l_r <= low_l_r + rnd_coef[SW-1:0];
      end
      if (cmd.wb_low_r) begin
        low_r_r <= low_r_r + rnd_coef[SW-1:0];
      end
      if (cmd.wb_amt) begin
        amt_r <= amt_r + rnd_coef[AW-1:0];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_x) begin
      x_l_r <= in_left_in;
      x_r_r <= in_right_in;
    end
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (cmd.load_mono) begin
      mono_r <= low_sum[SW:1];
    end
    if (cmd.load_res_l) begin
      res_l_r <= fin_sat;
    end
    if (cmd.load_out) begin
      out_l_r <= cmd.pass ? x_l_r : res_l_r;
      out_r_r <= cmd.pass ? x_r_r : fin_sat;
    end
  end

  assign out_left_out  = out_l_r;
  assign out_right_out = out_r_r;

endmodule

### tb/stereo_bass_mono_mixer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_bass_mono_mixer_tb: self-checking bench for the mono-bass mixer
// Streams stereo frames under several register settings and random idling on
// both channels. A bit-exact crossover predictor computes every frame's
// result, and each result leaving the block is compared with it in order.
// ----------------------------------------------------------------------------
module stereo_bass_mono_mixer_tb;
  import sbmm_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;   // cycles with no handshake at all
  localparam int PRINT_LIMIT    = 60;
  localparam int RAND_PHASES    = 11;
  localparam int PHASE_ITEMS    = 150;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef struct {
    sample_t left;
    sample_t right;
  } frame_t;

  localparam sample_t S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Crossover predictor plus the queue of frames it expects back
  class bass_mix_sb;
    bit                 enabled;
    bit [COEF_BITS-1:0] alpha;
    bit [COEF_BITS-1:0] smooth;
    bit [AMT_W-1:0]     target;
    longint             low_l, low_r, amount;
    frame_t             mixed_q[$];
    int                 mismatches;
    int                 results;

    function new();
      enabled    = 1'b0;
      alpha      = ALPHA_RESET;
      smooth     = SMOOTH_RESET;
      target     = TARGET_RESET;
      low_l      = 0;
      low_r      = 0;
      amount     = 0;
      mismatches = 0;
      results    = 0;
    endfunction

    // v / 2^s rounded to nearest, ties upward
    function longint round_shr(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // add the high residual back, drop guard bits, clip to the sample range
    function sample_t finish(longint x, longint low, longint blend);
      longint y;
      y = round_shr((x <<< GUARD_BITS) - low + blend, GUARD_BITS);
      if (y > longint'(S_MAX)) y = longint'(S_MAX);
      else if (y < longint'(S_MIN)) y = longint'(S_MIN);
      return sample_t'(y);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_ENABLE: begin
          // rising enable restarts the filters and the ramp
          if (!enabled && data[0]) begin
            low_l  = 0;
            low_r  = 0;
            amount = 0;
          end
          enabled = data[0];
        end
        REG_ALPHA:  alpha  = data[COEF_BITS-1:0];
        REG_SMOOTH: smooth = data[COEF_BITS-1:0];
        REG_TARGET: target = (data[AMT_W-1:0] > AMOUNT_ONE) ? AMT_W'(AMOUNT_ONE)
                                                            : data[AMT_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_frame(sample_t l, sample_t r);
      frame_t f;
      longint xl, xr, mono, bl, br;
      xl = l;
      xr = r;
      if (!enabled) begin
        f.left  = l;
        f.right = r;
      end else begin
        low_l  += round_shr(longint'(alpha) * ((xl <<< GUARD_BITS) - low_l), COEF_BITS);
        low_r  += round_shr(longint'(alpha) * ((xr <<< GUARD_BITS) - low_r), COEF_BITS);
        amount += round_shr(longint'(smooth) * (longint'(target) - amount), COEF_BITS);
        mono    = (low_l + low_r) >>> 1;
        bl      = low_l + round_shr((mono - low_l) * amount, AMOUNT_FRAC);
        br      = low_r + round_shr((mono - low_r) * amount, AMOUNT_FRAC);
        f.left  = finish(xl, low_l, bl);
        f.right = finish(xr, low_r, br);
      end
      mixed_q.push_back(f);
    endfunction

    function int pending();
      return mixed_q.size();
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) $display("%0t ns: %s", $time, msg);
    endtask

    task check_frame(sample_t l, sample_t r);
      frame_t want;
      results++;
      if (mixed_q.size() == 0) begin
        report($sformatf("result %0d arrived with no frame outstanding", results));
        return;
      end
      want = mixed_q.pop_front();
      if (l !== want.left)
        report($sformatf("result %0d left_out expected %0d, got %0d",
                         results, want.left, l));
      if (r !== want.right)
        report($sformatf("result %0d right_out expected %0d, got %0d",
                         results, want.right, r));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n       = 1'b0;
  logic                 cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = REG_ENABLE;
  logic [CFG_W-1:0]     cfg_data    = '0;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  sample_t              in_left_in  = '0;
  sample_t              in_right_in = '0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  sample_t              out_left_out;
  sample_t              out_right_out;

  bass_mix_sb sb = new();
  bit         calm = 1'b0;      // no idling on either side while set
  int         stall_run = 0;
  int         quiet_cycles = 0;
  int         walk_l = 0;
  int         walk_r = 0;

  stereo_bass_mono_mixer dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_left_in    (in_left_in),
    .in_right_in   (in_right_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_left_out  (out_left_out),
    .out_right_out (out_right_out)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: check accepted items, then pick the next stall pattern
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_frame(out_left_out, out_right_out);
    if (calm) begin
      out_stall <= 1'b0;
      stall_run = 0;
    end else if (stall_run > 0) begin
      stall_run = stall_run - 1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      stall_run = $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b1;
      stall_run = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60)
                                               : $urandom_range(0, 2);
    end
  end

  // Watchdog: too long without any handshake means the block hung
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 19) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic sample_t pick_edge();
    case ($urandom_range(0, 5))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return '0;
      3:       return '1;
      4:       return S_MAX - 1;
      default: return S_MIN + 1;
    endcase
  endfunction

  // bounded random walk, closer to audio than white noise
  function automatic int step_walk(int w);
    int v;
    v = w + int'($urandom_range(0, 1 << 19)) - (1 << 18);
    if (v > int'(S_MAX)) v = int'(S_MAX);
    if (v < int'(S_MIN)) v = int'(S_MIN);
    return v;
  endfunction

  // coefficient with a random unused top bit
  function automatic logic [CFG_W-1:0] pick_coef();
    logic [CFG_W-1:0] v;
    v = CFG_W'($urandom());
    case ($urandom_range(0, 5))
      0:       v[COEF_BITS-1:0] = '0;
      1:       v[COEF_BITS-1:0] = '1;
      2:       v[COEF_BITS-1:0] = COEF_BITS'($urandom_range(1, 4095));
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [CFG_W-1:0] pick_target();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return CFG_W'(AMOUNT_ONE);
      2:       return CFG_W'($urandom_range(AMOUNT_ONE + 1, 2 ** AMT_W - 1));
      default: return CFG_W'($urandom_range(0, AMOUNT_ONE));
    endcase
  endfunction

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // valid stays high from one item to the next unless a gap is drawn
  task automatic send_frame(sample_t l, sample_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_left_in  <= l;
    in_right_in <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_frame(l, r);
  endtask

  task automatic send_random_frame();
    sample_t l, r;
    case ($urandom_range(0, 9))
      0: begin
        l = pick_edge();
        r = pick_edge();
      end
      1, 2: begin
        l = sample_t'($urandom());
        r = sample_t'($urandom());
      end
      default: begin
        walk_l = step_walk(walk_l);
        walk_r = step_walk(walk_r);
        l = sample_t'(walk_l);
        r = sample_t'(walk_r);
      end
    endcase
    send_frame(l, r);
  endtask

  // wait for every outstanding result, then let the block go idle
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // disabled after reset: frames pass straight through
    send_frame(S_MAX, S_MIN);
    send_frame(S_MIN, S_MAX);
    send_frame('0, '1);
    send_frame(24'h555555, 24'hAAAAAA);
    settle();

    // enable with a fast ramp; a target above full mono is clipped to it
    set_reg(REG_ENABLE, CFG_W'(1));
    set_reg(REG_ALPHA, CFG_W'(16384));
    set_reg(REG_SMOOTH, CFG_W'(16'hFFFF));
    set_reg(REG_TARGET, '1);
    repeat (4) send_frame(S_MIN, S_MAX);
    // lows lag the polarity flip, so the residual pushes outputs into clipping
    repeat (2) send_frame(S_MAX, S_MIN);
    send_frame('0, '0);
    send_frame(S_MAX, S_MAX);
    settle();

    // enable rewritten while set keeps state; zero coefficients freeze it
    set_reg(REG_ENABLE, CFG_W'(1));
    set_reg(REG_ALPHA, '0);
    set_reg(REG_SMOOTH, '0);
    set_reg(REG_TARGET, '0);
    send_frame(S_MIN, S_MIN);
    send_frame(S_MAX, '0);
    send_frame(sample_t'(1), S_MIN);
    settle();

    // off then on again clears the lows and the ramp
    set_reg(REG_ENABLE, '0);
    send_frame(S_MIN, S_MAX);
    settle();
    set_reg(REG_ENABLE, CFG_W'(1));
    set_reg(REG_ALPHA, 17'h1FFFF);
    set_reg(REG_SMOOTH, CFG_W'(1));
    set_reg(REG_TARGET, CFG_W'(AMOUNT_ONE));
    send_frame(S_MAX, S_MIN);
    send_frame(S_MIN, S_MAX);
    send_frame(S_MAX, S_MAX);
    send_frame('1, '0);
    settle();

    // random settings, each followed by a run of random frames
    for (int p = 0; p < RAND_PHASES; p++) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) set_reg(REG_ENABLE, '0);
      set_reg(REG_ENABLE, CFG_W'($urandom_range(0, 6) != 0));
      if ($urandom_range(0, 3) != 0) set_reg(REG_ALPHA, pick_coef());
      if ($urandom_range(0, 3) != 0) set_reg(REG_SMOOTH, pick_coef());
      if ($urandom_range(0, 3) != 0) set_reg(REG_TARGET, pick_target());
      repeat (PHASE_ITEMS) send_random_frame();
      settle();
    end

    repeat (16) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
